FILE: src/compact_integer_encoder_defines.svh
// assertion macros for the compact integer encoder checker
`ifndef COMPACT_INTEGER_ENCODER_DEFINES_SVH
`define COMPACT_INTEGER_ENCODER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define CIE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define CIE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// holds in the cycle after reset is applied
`define CIE_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cie_pkg.sv
`default_nettype none

package cie_pkg;

    localparam int VALUE_W     = 128;
    localparam int HALF_W      = 64;
    localparam int VALUE_BYTES = VALUE_W / 8;
    localparam int FRAME_BYTES = VALUE_BYTES + 1;
    localparam int FRAME_W     = FRAME_BYTES * 8;
    localparam int LEN_W       = $clog2(FRAME_BYTES + 1);

    typedef logic [1:0] mode_t;

    // mode codes double as the tag bits of the first byte
    localparam mode_t MODE_ONE  = 2'b00;
    localparam mode_t MODE_TWO  = 2'b01;
    localparam mode_t MODE_FOUR = 2'b10;
    localparam mode_t MODE_BIG  = 2'b11;

    typedef struct packed {
        mode_t                    mode;
        logic [VALUE_BYTES-1:0]   nz;
        logic [VALUE_W-1:0]       value;
    } cls_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [FRAME_W-1:0] bytes;
    } frm_t;

endpackage

`default_nettype wire

FILE: src/cie_classify.sv
`default_nettype none

module cie_classify (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [cie_pkg::HALF_W-1:0]   in_low,
    input  wire logic [cie_pkg::HALF_W-1:0]   in_high,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output cie_pkg::cls_t                     out_cls
);

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [cie_pkg::HALF_W-1:0]     s1_low_reg;
    logic [cie_pkg::HALF_W-1:0]     s1_high_reg;
    logic                           s1_ready;

    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    cie_pkg::cls_t                  s2_cls_reg;
    cie_pkg::cls_t                  s2_cls_next;
    logic                           s2_ready;

    logic                           hi_zero;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    assign hi_zero = (s1_high_reg == '0);

    // size class and nonzero byte map
    always_comb begin
        s2_cls_next.value = {s1_high_reg, s1_low_reg};
        for (int i = 0; i < cie_pkg::VALUE_BYTES; i++) begin
            s2_cls_next.nz[i] = |s2_cls_next.value[i*8 +: 8];
        end
        priority if (hi_zero && s1_low_reg[cie_pkg::HALF_W-1:6] == '0) begin
            s2_cls_next.mode = cie_pkg::MODE_ONE;
        end else if (hi_zero && s1_low_reg[cie_pkg::HALF_W-1:14] == '0) begin
            s2_cls_next.mode = cie_pkg::MODE_TWO;
        end else if (hi_zero && s1_low_reg[cie_pkg::HALF_W-1:30] == '0) begin
            s2_cls_next.mode = cie_pkg::MODE_FOUR;
        end else begin
            s2_cls_next.mode = cie_pkg::MODE_BIG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && s1_ready) begin
            s1_low_reg  <= in_low;
            s1_high_reg <= in_high;
        end
        if (s1_valid_reg && s2_ready) begin
            s2_cls_reg <= s2_cls_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_cls   = s2_cls_reg;

endmodule

`default_nettype wire

FILE: src/cie_frame.sv
`default_nettype none

module cie_frame (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cie_pkg::cls_t in_cls,
    output logic               out_valid,
    input  wire logic          out_ready,
    output cie_pkg::frm_t      out_frm
);

    logic                           valid_reg;
    logic                           valid_next;
    cie_pkg::frm_t                  frm_reg;
    cie_pkg::frm_t                  frm_next;
    logic [cie_pkg::LEN_W-1:0]      count;
    logic [cie_pkg::LEN_W-1:0]      count_m4;
    logic [cie_pkg::HALF_W-1:0]     low;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign low        = in_cls.value[cie_pkg::HALF_W-1:0];

    // minimal byte count: index of the highest nonzero byte plus one
    always_comb begin
        count = '0;
        for (int i = 0; i < cie_pkg::VALUE_BYTES; i++) begin
            if (in_cls.nz[i]) begin
                count = cie_pkg::LEN_W'(i + 1);
            end
        end
        count_m4 = count - cie_pkg::LEN_W'(4);
    end

    always_comb begin
        frm_next.bytes = '0;
        frm_next.len   = '0;
        unique case (in_cls.mode)
            cie_pkg::MODE_ONE: begin
                frm_next.bytes[7:0] = {low[5:0], cie_pkg::MODE_ONE};
                frm_next.len        = cie_pkg::LEN_W'(1);
            end
            cie_pkg::MODE_TWO: begin
                frm_next.bytes[7:0]  = {low[5:0], cie_pkg::MODE_TWO};
                frm_next.bytes[15:8] = low[13:6];
                frm_next.len         = cie_pkg::LEN_W'(2);
            end
            cie_pkg::MODE_FOUR: begin
                frm_next.bytes[7:0]  = {low[5:0], cie_pkg::MODE_FOUR};
                frm_next.bytes[31:8] = low[29:6];
                frm_next.len         = cie_pkg::LEN_W'(4);
            end
            cie_pkg::MODE_BIG: begin
                // bytes above the count are zero, so the whole value can follow
                frm_next.bytes = {in_cls.value, 2'b00, count_m4[3:0], cie_pkg::MODE_BIG};
                frm_next.len   = count + cie_pkg::LEN_W'(1);
            end
            default: begin
                frm_next.bytes = '0;
                frm_next.len   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            frm_reg <= frm_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_frm   = frm_reg;

endmodule

`default_nettype wire

FILE: src/cie_serial.sv
`default_nettype none

module cie_serial (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cie_pkg::frm_t in_frm,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               out_last
);

    logic                           busy_reg;
    logic                           busy_next;
    logic [cie_pkg::FRAME_W-1:0]    shift_reg;
    logic [cie_pkg::FRAME_W-1:0]    shift_next;
    logic [cie_pkg::LEN_W-1:0]      rem_reg;
    logic [cie_pkg::LEN_W-1:0]      rem_next;
    logic                           at_last;
    logic                           take;

    assign at_last  = (rem_reg == cie_pkg::LEN_W'(1));
    assign take     = busy_reg && out_ready;
    assign in_ready = !busy_reg || (take && at_last);

    always_comb begin
        busy_next  = busy_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (in_valid && in_ready) begin
            busy_next  = 1'b1;
            shift_next = in_frm.bytes;
            rem_next   = in_frm.len;
        end else if (take) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                shift_next = {8'h00, shift_reg[cie_pkg::FRAME_W-1:8]};
                rem_next   = rem_reg - cie_pkg::LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    assign out_valid = busy_reg;
    assign out_byte  = shift_reg[7:0];
    assign out_last  = at_last;

endmodule

`default_nettype wire

FILE: src/compact_integer_encoder.sv
// compact integer encoder
// input: one unsigned 128-bit value per request on s_axis; tdata holds the
// low half in bits 63..0 and the high half in bits 127..64
// output: the compact encoding, one byte per request on m_axis, header or
// first byte first, the final byte of each value marked with tlast
// an encoding is 1, 2, 4 or 5 to 17 bytes long, by the size of the value
// the first byte of a value reaches m_axis once its request has passed two
// classify stages and a frame stage into the output shift register
// throughput: one byte per cycle while m_axis_tready is high, set by the
// single output byte lane; a value holds the output for all of its bytes
// (1 to 17); the next value enters while earlier ones are still in the pipe
// reset clears every stage's valid bit; the first cycle after reset shows
// no output and the block takes input at once
// a receiver stall holds the current byte and fills the stages behind it,
// then drops s_axis_tready; nothing is lost or repeated
`default_nettype none

module compact_integer_encoder (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [127:0]   s_axis_tdata,    // value_low[63:0], value_high[127:64]
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [7:0]          m_axis_tdata,    // out_byte[7:0]
    output logic                m_axis_tlast
);

    logic             cls_valid;
    logic             cls_ready;
    cie_pkg::cls_t    cls;
    logic             frm_valid;
    logic             frm_ready;
    cie_pkg::frm_t    frm;

    cie_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_low    (s_axis_tdata[cie_pkg::HALF_W-1:0]),
        .in_high   (s_axis_tdata[cie_pkg::VALUE_W-1:cie_pkg::HALF_W]),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_cls   (cls)
    );

    cie_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_cls    (cls),
        .out_valid (frm_valid),
        .out_ready (frm_ready),
        .out_frm   (frm)
    );

    cie_serial u_serial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (frm_valid),
        .in_ready  (frm_ready),
        .in_frm    (frm),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: src/cie_checker.sv
`default_nettype none

`include "compact_integer_encoder_defines.svh"

module cie_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [7:0]   m_axis_tdata,
    input  wire logic         m_axis_tlast
);

    logic first_reg;
    logic out_take;

    assign out_take = m_axis_tvalid && m_axis_tready;

    // marks the first byte of each encoding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (out_take) begin
            first_reg <= m_axis_tlast;
        end
    end

    `CIE_ASSERT_RST(a_reset_idle, !m_axis_tvalid, "output valid right after reset")

    `CIE_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled byte changed")

    `CIE_ASSERT_IMP(a_single_tag, out_take && first_reg, (m_axis_tdata[1:0] == 2'b00) == m_axis_tlast, "single byte tag and last mark disagree")

    `CIE_ASSERT_IMP(a_big_header, out_take && first_reg && m_axis_tdata[1:0] == 2'b11, m_axis_tdata[7:2] <= 6'd12 && !m_axis_tlast, "bad big mode header")

endmodule

bind compact_integer_encoder cie_checker u_cie_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/compact_integer_encoder_tb.sv
`default_nettype none

module compact_integer_encoder_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 460;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 120;
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 380;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic       drain;
        logic [127:0] value;
    } send_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } code_byte_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;    // value_low[63:0], value_high[127:64]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;         // out_byte[7:0]
    logic         m_axis_tlast;

    send_item_t send_q[$];
    code_byte_t code_bytes_due[$];

    int  values_taken = 0;
    int  failures = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  offer_taken = 1'b0;

    compact_integer_encoder u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void push_code_byte(input logic [7:0] data, input logic last);
        code_byte_t b;
        b.data = data;
        b.last = last;
        code_bytes_due.push_back(b);
    endfunction

    // expected byte run of one value
    function automatic void predict_encoding(input logic [127:0] v);
        int         n;
        logic [5:0] extra;
        n = 0;
        if (v <= 128'd63) begin
            push_code_byte({v[5:0], cie_pkg::MODE_ONE}, 1'b1);
        end else if (v <= 128'h3FFF) begin
            push_code_byte({v[5:0], cie_pkg::MODE_TWO}, 1'b0);
            push_code_byte(v[13:6], 1'b1);
        end else if (v <= 128'h3FFF_FFFF) begin
            push_code_byte({v[5:0], cie_pkg::MODE_FOUR}, 1'b0);
            push_code_byte(v[13:6], 1'b0);
            push_code_byte(v[21:14], 1'b0);
            push_code_byte(v[29:22], 1'b1);
        end else begin
            for (int k = 0; k < 16; k++) begin
                if (v[8*k +: 8] != 8'h00)
                    n = k + 1;
            end
            extra = 6'(n - 4);
            push_code_byte({extra, cie_pkg::MODE_BIG}, 1'b0);
            for (int k = 0; k < n; k++)
                push_code_byte(v[8*k +: 8], k == n - 1);
        end
    endfunction

    function automatic logic [127:0] random_value();
        logic [127:0] v;
        logic [127:0] mask;
        int           kind;
        int           nbytes;
        kind = $urandom_range(9);
        v = {$urandom(), $urandom(), $urandom(), $urandom()};
        case (kind)
            0: begin
                v = 128'($urandom_range(63));
            end
            1: begin
                v = 128'($urandom_range(32'h3FFF, 64));
            end
            2: begin
                v = 128'($urandom_range(32'h3FFF_FFFF, 32'h4000));
            end
            3, 4, 5: begin
                nbytes = $urandom_range(16, 4);
                mask = (128'd1 << (8 * nbytes)) - 128'd1;
                v = v & mask;
                v[8*nbytes-1 -: 8] = v[8*nbytes-1 -: 8] | (8'h01 << $urandom_range(7));
            end
            6: begin
                // around a mode boundary or a power of two
                case ($urandom_range(3))
                    0: v = 128'd63 + $urandom_range(2) - 1;
                    1: v = 128'h3FFF + $urandom_range(2) - 1;
                    2: v = 128'h3FFF_FFFF + $urandom_range(2) - 1;
                    default: v = (128'd1 << $urandom_range(127)) + $urandom_range(2) - 1;
                endcase
            end
            9: begin
                // one nonzero byte somewhere, zeros around it
                v = 128'(($urandom_range(255, 1))) << (8 * $urandom_range(15));
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic bit roll_idle();
        if (values_taken >= CALM_FROM && values_taken < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < 36;
    endfunction

    function automatic void queue_value(input logic [127:0] v);
        send_item_t it;
        it.drain = 1'b0;
        it.value = v;
        send_q.push_back(it);
    endfunction

    function automatic void queue_drain();
        send_item_t it;
        it.drain = 1'b1;
        it.value = '0;
        send_q.push_back(it);
    endfunction

    // request driver
    always @(negedge aclk) begin
        logic         next_valid;
        logic [127:0] next_data;
        send_item_t   it;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            offer_taken = 1'b0;
        end else begin
            next_valid = s_axis_tvalid;
            next_data = s_axis_tdata;
            if (!s_axis_tvalid || offer_taken) begin
                next_valid = 1'b0;
                if (send_q.size() > 0 && send_q[0].drain) begin
                    if (code_bytes_due.size() == 0)
                        void'(send_q.pop_front());
                end else if (send_q.size() > 0 && !roll_idle()) begin
                    it = send_q.pop_front();
                    next_data = it.value;
                    next_valid = 1'b1;
                end
            end
            offer_taken = 1'b0;
            s_axis_tvalid <= next_valid;
            s_axis_tdata <= next_data;
        end
    end

    // byte receiver with one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (!hold_done && values_taken >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !roll_idle();
            end
        end
    end

    // byte checker and request tracker
    always @(posedge aclk) begin
        code_byte_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (code_bytes_due.size() == 0) begin
                $error("unexpected byte: data %02h last %0b", m_axis_tdata, m_axis_tlast);
                failures++;
            end else begin
                want = code_bytes_due.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $error("out_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
                    failures++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_byte: expected %0b, actual %0b", want.last, m_axis_tlast);
                    failures++;
                end
            end
        end
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            predict_encoding(s_axis_tdata);
            values_taken++;
            offer_taken = 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        queue_value(128'd0);
        queue_value(128'd63);
        queue_value(128'd64);
        queue_value(128'h3FFF);
        queue_value(128'h3000);
        queue_value(128'h2ABC);
        queue_value(128'h4000);
        queue_value(128'h3FFF_FFFF);
        queue_value(128'h4000_0000);
        queue_value(128'hFFFF_FFFF);
        queue_value(128'h1_0000_0000);
        queue_value(128'hFFFF_FFFF_FFFF_FFFF);
        queue_value(128'h1_0000_0000_0000_0000);
        queue_value(128'h0100_0000_0000_0000_0000_0000);
        queue_value(128'h8000_0000_0000_0000_0000_0000_0000_0000);
        queue_value({128{1'b1}});
        queue_value(128'hA5A5_5A5A_0000_0000_0000_0000_C3C3_3C3C);
        queue_value(128'h0000_0000_0000_0001_0000_0000_0000_0000);
        queue_drain();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                queue_drain();
            queue_value(random_value());
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (send_q.size() > 0 || s_axis_tvalid || code_bytes_due.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0 && code_bytes_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
